### rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Depends on nothing; the including module must have clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication checked at every clock edge out of reset.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked at every clock edge out of reset.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(label, ante, cons, msg)
`define ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### rtl/jsv_pkg.sv
// Shared types, codes and tables of the JSON syntax validator.
// Depends on nothing; used by jsv_parser and json_syntax_validator.
package jsv_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam logic [7:0] MAX_DEPTH_RESET = 8'd128;

    // Event codes.
    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
    localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
    localparam logic [3:0] EV_ARR_OPEN  = 4'd3;
    localparam logic [3:0] EV_ARR_CLOSE = 4'd4;
    localparam logic [3:0] EV_NAME      = 4'd5;
    localparam logic [3:0] EV_STRING    = 4'd6;
    localparam logic [3:0] EV_NUMBER    = 4'd7;
    localparam logic [3:0] EV_LIT_BASE  = 4'd8;
    localparam logic [3:0] EV_DOC_END   = 4'd11;

    // Error codes.
    localparam logic [4:0] ERR_NONE       = 5'd0;
    localparam logic [4:0] ERR_NOT_STRING = 5'd1;
    localparam logic [4:0] ERR_CTRL_CHAR  = 5'd2;
    localparam logic [4:0] ERR_UTF8       = 5'd3;
    localparam logic [4:0] ERR_UESC       = 5'd4;
    localparam logic [4:0] ERR_SURROGATE  = 5'd5;
    localparam logic [4:0] ERR_ESCAPE     = 5'd6;
    localparam logic [4:0] ERR_UNTERM_STR = 5'd7;
    localparam logic [4:0] ERR_NUMBER     = 5'd8;
    localparam logic [4:0] ERR_EOF_VALUE  = 5'd9;
    localparam logic [4:0] ERR_EXP_VALUE  = 5'd10;
    localparam logic [4:0] ERR_NUL_MORE   = 5'd11;
    localparam logic [4:0] ERR_TRAILING   = 5'd12;
    localparam logic [4:0] ERR_UNEXP_END  = 5'd13;
    localparam logic [4:0] ERR_OBJ_COMMA  = 5'd14;
    localparam logic [4:0] ERR_COLON      = 5'd15;
    localparam logic [4:0] ERR_ARR_COMMA  = 5'd16;
    localparam logic [4:0] ERR_DEPTH      = 5'd18;

    // One result word.
    typedef struct packed {
        logic       accepted;
        logic [7:0] nest_depth;
        logic [4:0] error_code;
        logic [3:0] event_res;
    } jsv_result_t;

    // Characters of true, false and null by selector and position.
    function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (sel)
            2'd0: case (pos)
                3'd0: ch = "t"; 3'd1: ch = "r"; 3'd2: ch = "u"; 3'd3: ch = "e";
                default: ch = 8'h00;
            endcase
            2'd1: case (pos)
                3'd0: ch = "f"; 3'd1: ch = "a"; 3'd2: ch = "l"; 3'd3: ch = "s";
                3'd4: ch = "e";
                default: ch = 8'h00;
            endcase
            2'd2: case (pos)
                3'd0: ch = "n"; 3'd1: ch = "u"; 3'd2: ch = "l"; 3'd3: ch = "l";
                default: ch = 8'h00;
            endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] sel);
        return (sel == 2'd1) ? 3'd5 : 3'd4;
    endfunction

    // Hex digit: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
        else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
        else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
        return r;
    endfunction

endpackage

### rtl/jsv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module jsv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/jsv_parser.sv
// Grammar state and one-byte step logic of the JSON syntax validator.
// Depends on jsv_pkg and jsv_ram.
module jsv_parser
    import jsv_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    input  logic [7:0]  max_depth,
    output jsv_result_t res
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [4:0] {
        M_VALUE, M_OBJ_FIRST, M_OBJ_NAME, M_COLON, M_ARR_FIRST, M_AFTER,
        M_STR, M_ESC, M_UHEX, M_SURR_BS, M_SURR_U, M_SURR_HEX, M_UTF8, M_LIT,
        M_NUM_MINUS, M_NUM_ZERO, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_NUM_E,
        M_NUM_ESIGN, M_NUM_EXP, M_DONE
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic        name_reg, name_next;
    logic [7:0]  depth_reg, depth_next;
    logic [15:0] hex_reg, hex_next;
    logic [9:0]  hs_reg, hs_next;
    logic [2:0]  sub_reg, sub_next;
    logic [7:0]  lead_reg, lead_next;
    logic [4:0]  err_reg, err_next;
    logic        top_reg, top_next;
    logic        byp_reg, byp_data_reg;
    logic        push, pop, push_kind;
    logic        ram_wr_en, ram_rd_data, below;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [3:0]  ev;
    logic        acc;

    // The top kind lives in a register; the RAM holds the entries below it.
    assign below       = byp_reg ? byp_data_reg : ram_rd_data;
    assign ram_wr_en   = step && push && (depth_reg != 8'd0);
    assign ram_wr_addr = AW'(depth_reg - 8'd1);
    assign ram_rd_addr = AW'((step ? depth_next : depth_reg) - 8'd2);

    jsv_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (top_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Step logic for one byte.
    always_comb
    begin
        logic       ws, dig, in_str, do_value, do_after, do_fin, nul, second, hex_pass;
        logic [4:0] fc, hd;
        logic [7:0] c, lo, hi;
        logic [1:0] sel;
        logic [2:0] pos;

        c = byte_value;
        ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
        dig = (c >= "0") && (c <= "9");
        in_str = (mode_reg >= M_STR) && (mode_reg <= M_UTF8);
        hd = hex_digit(c);
        mode_next = mode_reg;
        name_next = name_reg;
        depth_next = depth_reg;
        hex_next = hex_reg;
        hs_next = hs_reg;
        sub_next = sub_reg;
        lead_next = lead_reg;
        err_next = err_reg;
        top_next = top_reg;
        push = 1'b0;
        pop = 1'b0;
        push_kind = 1'b0;
        ev = EV_NONE;
        acc = 1'b0;
        do_value = 1'b0;
        do_after = 1'b0;
        do_fin = 1'b0;
        nul = 1'b0;
        second = 1'b0;
        hex_pass = 1'b0;
        fc = ERR_NONE;
        lo = 8'h80;
        hi = 8'hBF;
        sel = 2'd0;
        pos = 3'd0;

        if (mode_reg != M_DONE && c == 8'h00 && !in_str)
        begin
            do_fin = 1'b1;
            nul = 1'b1;
        end
        else if (mode_reg != M_DONE)
        begin
            // Main per-mode handling.
            case (mode_reg)
                M_VALUE: do_value = 1'b1;
                M_OBJ_FIRST:
                    if (!ws)
                    begin
                        if (c == "}") pop = 1'b1;
                        else if (c == "\"") begin name_next = 1'b1; ev = EV_NAME;
                            mode_next = M_STR; end
                        else fc = ERR_NOT_STRING;
                    end
                M_OBJ_NAME:
                    if (!ws)
                    begin
                        if (c == "\"") begin name_next = 1'b1; ev = EV_NAME;
                            mode_next = M_STR; end
                        else fc = ERR_NOT_STRING;
                    end
                M_COLON:
                    if (!ws)
                    begin
                        if (c == ":") mode_next = M_VALUE;
                        else fc = ERR_COLON;
                    end
                M_ARR_FIRST:
                    if (c == "]") pop = 1'b1;
                    else do_value = 1'b1;
                M_AFTER: do_after = 1'b1;
                M_STR:
                    if (c < 8'h20) fc = ERR_CTRL_CHAR;
                    else if (c == "\"") mode_next = name_reg ? M_COLON : M_AFTER;
                    else if (c == "\\") mode_next = M_ESC;
                    else if (c >= 8'h80)
                    begin
                        if (c >= 8'hC2 && c <= 8'hDF) sub_next = 3'd1;
                        else if (c >= 8'hE0 && c <= 8'hEF) sub_next = 3'd2;
                        else if (c >= 8'hF0 && c <= 8'hF4) sub_next = 3'd3;
                        else fc = ERR_UTF8;
                        if (fc == ERR_NONE)
                        begin
                            lead_next = c;
                            mode_next = M_UTF8;
                        end
                    end
                M_ESC:
                    if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                        c == "n" || c == "r" || c == "t") mode_next = M_STR;
                    else if (c == "u")
                    begin
                        hex_next = 16'd0;
                        sub_next = 3'd0;
                        mode_next = M_UHEX;
                    end
                    else fc = ERR_ESCAPE;
                M_UHEX: hex_pass = 1'b1;
                M_SURR_BS:
                    if (c == "\\") mode_next = M_SURR_U;
                    else fc = ERR_SURROGATE;
                M_SURR_U:
                    if (c == "u")
                    begin
                        hex_next = 16'd0;
                        sub_next = 3'd0;
                        mode_next = M_SURR_HEX;
                    end
                    else fc = ERR_SURROGATE;
                M_SURR_HEX:
                begin
                    hex_pass = 1'b1;
                    second = 1'b1;
                end
                M_UTF8:
                begin
                    if (lead_reg == 8'hE0) lo = 8'hA0;
                    if (lead_reg == 8'hED) hi = 8'h9F;
                    if (lead_reg == 8'hF0) lo = 8'h90;
                    if (lead_reg == 8'hF4) hi = 8'h8F;
                    if (c < lo || c > hi) fc = ERR_UTF8;
                    else
                    begin
                        lead_next = 8'd0;
                        sub_next = sub_reg - 3'd1;
                        if (sub_reg == 3'd1) mode_next = M_STR;
                    end
                end
                M_LIT:
                begin
                    sel = (lead_reg < 8'd3) ? lead_reg[1:0] : 2'd0;
                    pos = (sub_reg < 3'd5) ? sub_reg : 3'd5;
                    if (c != lit_char(sel, pos)) fc = ERR_EXP_VALUE;
                    else
                    begin
                        sub_next = sub_reg + 3'd1;
                        if ((sub_reg + 3'd1) >= lit_len(sel)) mode_next = M_AFTER;
                    end
                end
                M_NUM_MINUS:
                    if (c == "0") mode_next = M_NUM_ZERO;
                    else if (c >= "1" && c <= "9") mode_next = M_NUM_INT;
                    else fc = ERR_NUMBER;
                M_NUM_ZERO, M_NUM_INT:
                    if (mode_reg == M_NUM_INT && dig) mode_next = M_NUM_INT;
                    else if (c == ".") mode_next = M_NUM_DOT;
                    else if (c == "e" || c == "E") mode_next = M_NUM_E;
                    else do_after = 1'b1;
                M_NUM_DOT:
                    if (dig) mode_next = M_NUM_FRAC;
                    else fc = (depth_reg == 8'd0) ? ERR_TRAILING :
                              (top_reg ? ERR_ARR_COMMA : ERR_OBJ_COMMA);
                M_NUM_FRAC:
                    if (c == "e" || c == "E") mode_next = M_NUM_E;
                    else if (!dig) do_after = 1'b1;
                M_NUM_E:
                    if (dig) mode_next = M_NUM_EXP;
                    else if (c == "+" || c == "-") mode_next = M_NUM_ESIGN;
                    else fc = (depth_reg == 8'd0) ? ERR_TRAILING :
                              (top_reg ? ERR_ARR_COMMA : ERR_OBJ_COMMA);
                M_NUM_ESIGN:
                    if (dig) mode_next = M_NUM_EXP;
                    else fc = (depth_reg == 8'd0) ? ERR_TRAILING :
                              (top_reg ? ERR_ARR_COMMA : ERR_OBJ_COMMA);
                M_NUM_EXP:
                    if (!dig) do_after = 1'b1;
                default: mode_next = mode_reg;
            endcase

            // Four-digit \u escape, first or second half of a pair.
            if (hex_pass)
            begin
                if (!hd[4]) fc = second ? ERR_SURROGATE : ERR_UESC;
                else
                begin
                    hex_next = {hex_reg[11:0], hd[3:0]};
                    sub_next = sub_reg + 3'd1;
                    if (sub_reg == 3'd3)
                    begin
                        if (second)
                        begin
                            if (hex_next >= 16'hDC00 && hex_next <= 16'hDFFF)
                                mode_next = M_STR;
                            else fc = ERR_SURROGATE;
                        end
                        else if (hex_next >= 16'hD800 && hex_next <= 16'hDBFF)
                        begin
                            hs_next = hex_next[9:0];
                            mode_next = M_SURR_BS;
                        end
                        else if (hex_next >= 16'hDC00 && hex_next <= 16'hDFFF)
                            fc = ERR_SURROGATE;
                        else mode_next = M_STR;
                    end
                end
            end

            // Start of a value.
            if (do_value && !ws)
            begin
                if (c == "\"") begin name_next = 1'b0; ev = EV_STRING; mode_next = M_STR; end
                else if (c == "-") begin ev = EV_NUMBER; mode_next = M_NUM_MINUS; end
                else if (c == "0") begin ev = EV_NUMBER; mode_next = M_NUM_ZERO; end
                else if (c >= "1" && c <= "9") begin ev = EV_NUMBER; mode_next = M_NUM_INT; end
                else if (c == "t" || c == "f" || c == "n")
                begin
                    sel = (c == "t") ? 2'd0 : ((c == "f") ? 2'd1 : 2'd2);
                    lead_next = {6'd0, sel};
                    sub_next = 3'd1;
                    ev = EV_LIT_BASE + {2'd0, sel};
                    mode_next = M_LIT;
                end
                else if (c == "{" || c == "[")
                begin
                    if (depth_reg >= max_depth || int'(depth_reg) >= STACK_DEPTH)
                        fc = ERR_DEPTH;
                    else
                    begin
                        push = 1'b1;
                        push_kind = (c == "[");
                        depth_next = depth_reg + 8'd1;
                        ev = push_kind ? EV_ARR_OPEN : EV_OBJ_OPEN;
                        mode_next = push_kind ? M_ARR_FIRST : M_OBJ_FIRST;
                    end
                end
                else fc = ERR_EXP_VALUE;
            end

            // Byte after a complete value.
            if (do_after)
            begin
                mode_next = M_AFTER;
                if (!ws)
                begin
                    if (depth_reg == 8'd0) fc = ERR_TRAILING;
                    else if (top_reg)
                    begin
                        if (c == "]") pop = 1'b1;
                        else if (c == ",") mode_next = M_VALUE;
                        else fc = ERR_ARR_COMMA;
                    end
                    else
                    begin
                        if (c == "}") pop = 1'b1;
                        else if (c == ",") mode_next = M_OBJ_NAME;
                        else fc = ERR_OBJ_COMMA;
                    end
                end
            end

            // Close of the innermost object or array.
            if (pop)
            begin
                ev = top_reg ? EV_ARR_CLOSE : EV_OBJ_CLOSE;
                if (depth_reg != 8'd0) depth_next = depth_reg - 8'd1;
                mode_next = M_AFTER;
            end

            if (fc != ERR_NONE)
            begin
                if (err_next == ERR_NONE) err_next = fc;
                mode_next = M_DONE;
            end
            do_fin = last_byte && (mode_next != M_DONE);
        end

        // End of the document.
        if (do_fin)
        begin
            fc = ERR_NONE;
            case (mode_next)
                M_VALUE: fc = ERR_EOF_VALUE;
                M_OBJ_FIRST, M_ARR_FIRST: fc = ERR_UNEXP_END;
                M_OBJ_NAME: fc = ERR_NOT_STRING;
                M_COLON: fc = ERR_COLON;
                M_NUM_ZERO, M_NUM_INT, M_NUM_FRAC, M_NUM_EXP, M_AFTER:
                    if (depth_next != 8'd0) fc = ERR_UNEXP_END;
                    else if (nul && !last_byte) fc = ERR_NUL_MORE;
                    else
                    begin
                        acc = 1'b1;
                        mode_next = M_DONE;
                    end
                M_STR, M_ESC: fc = ERR_UNTERM_STR;
                M_UHEX: fc = ERR_UESC;
                M_SURR_BS, M_SURR_U, M_SURR_HEX: fc = ERR_SURROGATE;
                M_UTF8: fc = ERR_UTF8;
                M_LIT: fc = ERR_EXP_VALUE;
                M_NUM_MINUS: fc = ERR_NUMBER;
                M_NUM_DOT, M_NUM_E, M_NUM_ESIGN:
                    fc = (depth_next == 8'd0) ? ERR_TRAILING :
                         (top_reg ? ERR_ARR_COMMA : ERR_OBJ_COMMA);
                default: fc = ERR_NONE;
            endcase
            if (fc != ERR_NONE)
            begin
                if (err_next == ERR_NONE) err_next = fc;
                mode_next = M_DONE;
            end
        end

        top_next = push ? push_kind : (pop ? below : top_reg);

        res.accepted   = acc;
        res.nest_depth = depth_next;
        res.error_code = err_next;
        res.event_res  = acc ? EV_DOC_END : ((err_next != ERR_NONE) ? EV_NONE : ev);
    end

    // Parse state, updated on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_VALUE;
            name_reg     <= 1'b0;
            depth_reg    <= 8'd0;
            hex_reg      <= 16'd0;
            hs_reg       <= 10'd0;
            sub_reg      <= 3'd0;
            lead_reg     <= 8'd0;
            err_reg      <= ERR_NONE;
            top_reg      <= 1'b0;
            byp_reg      <= 1'b0;
            byp_data_reg <= 1'b0;
        end
        else
        begin
            byp_reg      <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
            byp_data_reg <= top_reg;
            if (step)
            begin
                mode_reg  <= mode_next;
                name_reg  <= name_next;
                depth_reg <= depth_next;
                hex_reg   <= hex_next;
                hs_reg    <= hs_next;
                sub_reg   <= sub_next;
                lead_reg  <= lead_next;
                err_reg   <= err_next;
                top_reg   <= top_next;
            end
        end
    end

endmodule

### rtl/json_syntax_validator.sv
// Top level of the JSON syntax validator: config register and result queue.
// Depends on jsv_pkg, jsv_parser, jsv_ram and assert_macros.svh.
//
// Channel   Direction  Word
// s_*       in         tdata[7:0] byte_value, tlast last_byte
// m_*       out        tdata: event_res, error_code, nest_depth, accepted
// cfg_*     in         max_depth, written whenever cfg_wen is high
//
// One byte per clock while s_tready is high: each byte is checked by the parse step in the cycle it
// is taken, and its result word is registered into the result queue.
// A two-word result queue decouples the sides; s_tready drops only when both
// words wait. Reset clears the parse state and the queue; the nesting stack
// RAM needs no clearing.
`include "assert_macros.svh"
module json_syntax_validator
    import jsv_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] event_res, [8:4] error_code,
                                   // [16:9] nest_depth, [17] accepted, rest 0
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata  // max_depth
);

    logic [7:0]  max_depth_reg;
    logic [1:0]  count_reg, count_next;
    jsv_result_t slot0_reg, slot1_reg, res;
    logic        take_in, take_out;

    assign s_tready = (count_reg != 2'd2);
    assign take_in  = s_tvalid && s_tready;
    assign take_out = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {6'd0, slot0_reg};
    assign count_next = count_reg + {1'b0, take_in} - {1'b0, take_out};

    jsv_parser #(.STACK_DEPTH(STACK_DEPTH)) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (take_in),
        .byte_value (s_tdata),
        .last_byte  (s_tlast),
        .max_depth  (max_depth_reg),
        .res        (res)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= MAX_DEPTH_RESET;
        end
        else if (cfg_wen)
        begin
            max_depth_reg <= cfg_wdata;
        end
    end

    // Two-word result queue; slot0 is the head.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            slot0_reg <= (count_reg == 2'd2) ? slot1_reg : res;
            if (take_in && count_reg == 2'd2)
            begin
                slot1_reg <= res;
            end
        end
        else if (take_in)
        begin
            if (count_reg == 2'd0) slot0_reg <= res;
            else slot1_reg <= res;
        end
    end

    // Checks.
    `ASSERT_IMP(a_full_stalls, count_reg == 2'd2, !s_tready, "queue full but input ready")
    `ASSERT_IMP(a_accept_event, m_tvalid && m_tdata[17], m_tdata[3:0] == EV_DOC_END,
        "accepted word without document end event")
    `ASSERT_IMP(a_error_quiet, m_tvalid && (m_tdata[8:4] != ERR_NONE),
        (m_tdata[3:0] == EV_NONE) && !m_tdata[17], "error word carries an event")
    `ASSERT_NXT(a_queue_fill, take_in && !take_out && count_reg != 2'd2,
        count_reg == $past(count_reg) + 2'd1, "queue count lost a word")

endmodule

### bench/json_syntax_validator_chk.sv
// Checker for the JSON syntax validator: watches the byte, result and config ports.
// It tracks the parse state itself, predicts each result word and compares it.
// Depends on jsv_pkg for the result layout and the event and error codes.
module json_syntax_validator_chk
    import jsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [5:0] {
        PM_VALUE, PM_OBJ_FIRST, PM_OBJ_NAME, PM_COLON, PM_ARR_FIRST, PM_AFTER,
        PM_STR, PM_ESC, PM_UHEX, PM_SURR_BS, PM_SURR_U, PM_SURR_HEX, PM_UTF8,
        PM_LIT, PM_NUM_MINUS, PM_NUM_ZERO, PM_NUM_INT, PM_NUM_DOT, PM_NUM_FRAC,
        PM_NUM_E, PM_NUM_ESIGN, PM_NUM_EXP, PM_DONE
    } parse_mode_e;

    localparam int STK = STACK_DEPTH_DEF;

    // Parser state as the block should hold it.
    parse_mode_e mode;
    bit          name_flag;
    bit          kind_stk [STK];
    logic [7:0]  depth;
    logic [15:0] hex_acc;
    logic [9:0]  hi_surr;
    logic [2:0]  sub;
    logic [7:0]  lead;
    logic [4:0]  err;
    logic [3:0]  ev;
    bit          acc;
    logic [7:0]  depth_lim;

    jsv_result_t result_q[$];
    string       lit_word [3] = '{"true", "false", "null"};

    function automatic bit is_ws(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int hex_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic fail(logic [4:0] code);
        if (err == ERR_NONE)
            err = code;
        mode = PM_DONE;
    endtask

    function automatic bit top_is_arr();
        if (depth == 0 || depth > STK)
            return 1'b0;
        return kind_stk[depth - 1];
    endfunction

    task automatic after_value_err();
        if (depth == 0) fail(ERR_TRAILING);
        else if (top_is_arr()) fail(ERR_ARR_COMMA);
        else fail(ERR_OBJ_COMMA);
    endtask

    task automatic open_nest(bit is_arr);
        int lim;
        lim = (depth_lim < STK) ? depth_lim : STK;
        if (depth >= lim)
        begin
            fail(ERR_DEPTH);
            return;
        end
        kind_stk[depth] = is_arr;
        depth = depth + 1;
        ev = is_arr ? EV_ARR_OPEN : EV_OBJ_OPEN;
        mode = is_arr ? PM_ARR_FIRST : PM_OBJ_FIRST;
    endtask

    task automatic close_nest();
        ev = top_is_arr() ? EV_ARR_CLOSE : EV_OBJ_CLOSE;
        if (depth > 0)
            depth = depth - 1;
        mode = PM_AFTER;
    endtask

    task automatic open_string(bit is_name);
        name_flag = is_name;
        ev = is_name ? EV_NAME : EV_STRING;
        mode = PM_STR;
    endtask

    task automatic open_literal(logic [1:0] sel);
        lead = sel;
        sub = 3'd1;
        ev = EV_LIT_BASE + sel;
        mode = PM_LIT;
    endtask

    task automatic value_start(logic [7:0] c);
        if (is_ws(c)) return;
        if (c == "\"") open_string(1'b0);
        else if (c == "-")
        begin
            ev = EV_NUMBER;
            mode = PM_NUM_MINUS;
        end
        else if (c == "0")
        begin
            ev = EV_NUMBER;
            mode = PM_NUM_ZERO;
        end
        else if (c >= "1" && c <= "9")
        begin
            ev = EV_NUMBER;
            mode = PM_NUM_INT;
        end
        else if (c == "t") open_literal(2'd0);
        else if (c == "f") open_literal(2'd1);
        else if (c == "n") open_literal(2'd2);
        else if (c == "{") open_nest(1'b0);
        else if (c == "[") open_nest(1'b1);
        else fail(ERR_EXP_VALUE);
    endtask

    // One hex digit of a \u escape; the second escape of a pair must be a low surrogate.
    task automatic hex_step(logic [7:0] c, bit second);
        int d;
        d = hex_of(c);
        if (d < 0)
        begin
            fail(second ? ERR_SURROGATE : ERR_UESC);
            return;
        end
        hex_acc = {hex_acc[11:0], 4'(d)};
        sub = sub + 1;
        if (sub < 4) return;
        if (second)
        begin
            if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) mode = PM_STR;
            else fail(ERR_SURROGATE);
        end
        else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF)
        begin
            hi_surr = hex_acc[9:0];
            mode = PM_SURR_BS;
        end
        else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) fail(ERR_SURROGATE);
        else mode = PM_STR;
    endtask

    task automatic string_step(logic [7:0] c);
        if (c < 8'h20) fail(ERR_CTRL_CHAR);
        else if (c == "\"") mode = name_flag ? PM_COLON : PM_AFTER;
        else if (c == "\\") mode = PM_ESC;
        else if (c >= 8'h80)
        begin
            if (c >= 8'hC2 && c <= 8'hDF) sub = 3'd1;
            else if (c >= 8'hE0 && c <= 8'hEF) sub = 3'd2;
            else if (c >= 8'hF0 && c <= 8'hF4) sub = 3'd3;
            else
            begin
                fail(ERR_UTF8);
                return;
            end
            lead = c;
            mode = PM_UTF8;
        end
    endtask

    // Continuation byte; some lead bytes narrow the allowed range of the first one.
    task automatic utf8_step(logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (lead == 8'hE0) lo = 8'hA0;
        if (lead == 8'hED) hi = 8'h9F;
        if (lead == 8'hF0) lo = 8'h90;
        if (lead == 8'hF4) hi = 8'h8F;
        if (c < lo || c > hi)
        begin
            fail(ERR_UTF8);
            return;
        end
        lead = 8'h00;
        sub = sub - 1;
        if (sub == 0)
            mode = PM_STR;
    endtask

    // Grammar step for one byte; a byte that ends a number is handled again as a follower.
    task automatic grammar_step(logic [7:0] c);
        bit again;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (mode)
                PM_VALUE: value_start(c);
                PM_OBJ_FIRST:
                    if (!is_ws(c))
                    begin
                        if (c == "}") close_nest();
                        else if (c == "\"") open_string(1'b1);
                        else fail(ERR_NOT_STRING);
                    end
                PM_OBJ_NAME:
                    if (!is_ws(c))
                    begin
                        if (c == "\"") open_string(1'b1);
                        else fail(ERR_NOT_STRING);
                    end
                PM_COLON:
                    if (!is_ws(c))
                    begin
                        if (c == ":") mode = PM_VALUE;
                        else fail(ERR_COLON);
                    end
                PM_ARR_FIRST:
                    if (c == "]") close_nest();
                    else value_start(c);
                PM_AFTER:
                    if (!is_ws(c))
                    begin
                        if (depth == 0) fail(ERR_TRAILING);
                        else if (top_is_arr())
                        begin
                            if (c == "]") close_nest();
                            else if (c == ",") mode = PM_VALUE;
                            else fail(ERR_ARR_COMMA);
                        end
                        else
                        begin
                            if (c == "}") close_nest();
                            else if (c == ",") mode = PM_OBJ_NAME;
                            else fail(ERR_OBJ_COMMA);
                        end
                    end
                PM_STR: string_step(c);
                PM_ESC:
                    if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                        c == "n" || c == "r" || c == "t")
                        mode = PM_STR;
                    else if (c == "u")
                    begin
                        hex_acc = 16'h0;
                        sub = 3'd0;
                        mode = PM_UHEX;
                    end
                    else fail(ERR_ESCAPE);
                PM_UHEX: hex_step(c, 1'b0);
                PM_SURR_BS:
                    if (c == "\\") mode = PM_SURR_U;
                    else fail(ERR_SURROGATE);
                PM_SURR_U:
                    if (c == "u")
                    begin
                        hex_acc = 16'h0;
                        sub = 3'd0;
                        mode = PM_SURR_HEX;
                    end
                    else fail(ERR_SURROGATE);
                PM_SURR_HEX: hex_step(c, 1'b1);
                PM_UTF8: utf8_step(c);
                PM_LIT:
                    if (c != lit_word[lead][sub]) fail(ERR_EXP_VALUE);
                    else
                    begin
                        sub = sub + 1;
                        if (sub >= lit_word[lead].len()) mode = PM_AFTER;
                    end
                PM_NUM_MINUS:
                    if (c == "0") mode = PM_NUM_ZERO;
                    else if (c >= "1" && c <= "9") mode = PM_NUM_INT;
                    else fail(ERR_NUMBER);
                PM_NUM_ZERO, PM_NUM_INT:
                    if (!(mode == PM_NUM_INT && is_dig(c)))
                    begin
                        if (c == ".") mode = PM_NUM_DOT;
                        else if (c == "e" || c == "E") mode = PM_NUM_E;
                        else
                        begin
                            mode = PM_AFTER;
                            again = 1'b1;
                        end
                    end
                PM_NUM_DOT:
                    if (is_dig(c)) mode = PM_NUM_FRAC;
                    else after_value_err();
                PM_NUM_FRAC:
                    if (!is_dig(c))
                    begin
                        if (c == "e" || c == "E") mode = PM_NUM_E;
                        else
                        begin
                            mode = PM_AFTER;
                            again = 1'b1;
                        end
                    end
                PM_NUM_E:
                    if (is_dig(c)) mode = PM_NUM_EXP;
                    else if (c == "+" || c == "-") mode = PM_NUM_ESIGN;
                    else after_value_err();
                PM_NUM_ESIGN:
                    if (is_dig(c)) mode = PM_NUM_EXP;
                    else after_value_err();
                PM_NUM_EXP:
                    if (!is_dig(c))
                    begin
                        mode = PM_AFTER;
                        again = 1'b1;
                    end
                default: ;
            endcase
        end
    endtask

    // End of document applied to the state left by the byte.
    task automatic doc_end(bit nul, bit last);
        case (mode)
            PM_VALUE: fail(ERR_EOF_VALUE);
            PM_OBJ_FIRST, PM_ARR_FIRST: fail(ERR_UNEXP_END);
            PM_OBJ_NAME: fail(ERR_NOT_STRING);
            PM_COLON: fail(ERR_COLON);
            PM_NUM_ZERO, PM_NUM_INT, PM_NUM_FRAC, PM_NUM_EXP, PM_AFTER:
                if (depth != 0) fail(ERR_UNEXP_END);
                else if (nul && !last) fail(ERR_NUL_MORE);
                else
                begin
                    acc = 1'b1;
                    mode = PM_DONE;
                end
            PM_STR, PM_ESC: fail(ERR_UNTERM_STR);
            PM_UHEX: fail(ERR_UESC);
            PM_SURR_BS, PM_SURR_U, PM_SURR_HEX: fail(ERR_SURROGATE);
            PM_UTF8: fail(ERR_UTF8);
            PM_LIT: fail(ERR_EXP_VALUE);
            PM_NUM_MINUS: fail(ERR_NUMBER);
            PM_NUM_DOT, PM_NUM_E, PM_NUM_ESIGN: after_value_err();
            default: ;
        endcase
    endtask

    task automatic predict_word(logic [7:0] c, bit last, output jsv_result_t r);
        bit in_str;
        in_str = (mode >= PM_STR && mode <= PM_UTF8);
        ev = EV_NONE;
        acc = 1'b0;
        if (mode != PM_DONE)
        begin
            if (c == 8'h00 && !in_str)
                doc_end(1'b1, last);
            else
            begin
                grammar_step(c);
                if (last && mode != PM_DONE)
                    doc_end(1'b0, 1'b1);
            end
        end
        r.event_res  = acc ? EV_DOC_END : ((err != ERR_NONE) ? EV_NONE : ev);
        r.error_code = err;
        r.nest_depth = depth;
        r.accepted   = acc;
    endtask

    // Track config writes, predict each accepted byte and compare each result word.
    always @(posedge clk or negedge rst_n)
    begin
        jsv_result_t want;
        jsv_result_t got;
        if (!rst_n)
        begin
            mode = PM_VALUE;
            name_flag = 1'b0;
            depth = 8'd0;
            hex_acc = 16'd0;
            hi_surr = 10'd0;
            sub = 3'd0;
            lead = 8'd0;
            err = ERR_NONE;
            depth_lim = MAX_DEPTH_RESET;
            result_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_wen)
                depth_lim = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                predict_word(s_tdata, s_tlast, want);
                result_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[17:0];
                if (result_q.size() == 0)
                begin
                    $display("%0t: result word %h with no byte waiting", $time, m_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got !== want || m_tdata[23:18] !== 6'd0)
                    begin
                        $display("%0t: mismatch expected ev=%0d err=%0d depth=%0d acc=%0d",
                                 $time, want.event_res, want.error_code,
                                 want.nest_depth, want.accepted);
                        $display("%0t:          actual   ev=%0d err=%0d depth=%0d acc=%0d pad=%h",
                                 $time, got.event_res, got.error_code,
                                 got.nest_depth, got.accepted, m_tdata[23:18]);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        pending = result_q.size();
    end

endmodule

### bench/json_syntax_validator_tb.sv
// Top of the JSON syntax validator bench: clock, reset, document stimulus and verdict.
// Depends on jsv_pkg, json_syntax_validator and json_syntax_validator_chk.
module json_syntax_validator_tb;
    import jsv_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] byte_value
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [3:0] event_res, [8:4] error_code, [16:9] nest_depth, [17] accepted
    logic        cfg_wen;
    logic [7:0]  cfg_wdata;
    int          fail_count;
    int          pending;
    int          bytes_sent;
    int          rx_cycle;
    logic [7:0]  doc_q[$];

    json_syntax_validator u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    json_syntax_validator_chk u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, one long hold-off so the queue fills, one stretch with none.
    initial
    begin
        m_tready = 1'b0;
        rx_cycle = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle = rx_cycle + 1;
            if (rx_cycle >= 1500 && rx_cycle < 1800)
                m_tready <= 1'b0;
            else if (rx_cycle >= 2500 && rx_cycle < 3000)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 12);
        end
    end

    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return "0" + n;
        return 8'(($urandom_range(1) ? "A" : "a") + n - 10);
    endfunction

    task automatic add_text(string s);
        foreach (s[i])
            doc_q.push_back(s[i]);
    endtask

    task automatic add_ws();
        int n;
        n = $urandom_range(2);
        repeat (n)
            case ($urandom_range(3))
                0: doc_q.push_back(8'h20);
                1: doc_q.push_back(8'h09);
                2: doc_q.push_back(8'h0A);
                default: doc_q.push_back(8'h0D);
            endcase
    endtask

    task automatic add_uesc(logic [15:0] v);
        add_text("\\u");
        for (int i = 3; i >= 0; i--)
            doc_q.push_back(hex_char(v[i*4 +: 4]));
    endtask

    function automatic logic [7:0] cont_byte(logic [7:0] lo, logic [7:0] hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // Well-formed string with plain text, escapes, \u and surrogate pairs and UTF-8.
    task automatic add_string();
        int n;
        logic [15:0] u;
        logic [7:0] c;
        doc_q.push_back("\"");
        n = $urandom_range(6);
        repeat (n)
            case ($urandom_range(9))
                0: add_text("\\\\");
                1:
                begin
                    doc_q.push_back("\\");
                    case ($urandom_range(7))
                        0: doc_q.push_back("\""); 1: doc_q.push_back("\\");
                        2: doc_q.push_back("/");  3: doc_q.push_back("b");
                        4: doc_q.push_back("f");  5: doc_q.push_back("n");
                        6: doc_q.push_back("r");  default: doc_q.push_back("t");
                    endcase
                end
                2:
                begin
                    u = 16'($urandom);
                    if (u >= 16'hD800 && u <= 16'hDFFF)
                        u = u ^ 16'h8000;
                    add_uesc(u);
                end
                3:
                begin
                    add_uesc(16'hD800 + 16'($urandom_range(16'h3FF)));
                    add_uesc(16'hDC00 + 16'($urandom_range(16'h3FF)));
                end
                4:
                begin
                    doc_q.push_back(8'($urandom_range(8'hDF, 8'hC2)));
                    doc_q.push_back(cont_byte(8'h80, 8'hBF));
                end
                5:
                begin
                    c = 8'($urandom_range(8'hEF, 8'hE0));
                    doc_q.push_back(c);
                    doc_q.push_back(cont_byte(c == 8'hE0 ? 8'hA0 : 8'h80,
                                              c == 8'hED ? 8'h9F : 8'hBF));
                    doc_q.push_back(cont_byte(8'h80, 8'hBF));
                end
                6:
                begin
                    c = 8'($urandom_range(8'hF4, 8'hF0));
                    doc_q.push_back(c);
                    doc_q.push_back(cont_byte(c == 8'hF0 ? 8'h90 : 8'h80,
                                              c == 8'hF4 ? 8'h8F : 8'hBF));
                    doc_q.push_back(cont_byte(8'h80, 8'hBF));
                    doc_q.push_back(cont_byte(8'h80, 8'hBF));
                end
                default:
                begin
                    c = 8'($urandom_range(8'h7E, 8'h20));
                    if (c == "\"" || c == "\\")
                        c = "q";
                    doc_q.push_back(c);
                end
            endcase
        doc_q.push_back("\"");
    endtask

    task automatic add_number();
        int n;
        if ($urandom_range(2) == 0) doc_q.push_back("-");
        if ($urandom_range(3) == 0) doc_q.push_back("0");
        else
        begin
            doc_q.push_back(8'($urandom_range("9", "1")));
            n = $urandom_range(3);
            repeat (n) doc_q.push_back(8'($urandom_range("9", "0")));
        end
        if ($urandom_range(1))
        begin
            doc_q.push_back(".");
            n = $urandom_range(3, 1);
            repeat (n) doc_q.push_back(8'($urandom_range("9", "0")));
        end
        if ($urandom_range(2) == 0)
        begin
            doc_q.push_back($urandom_range(1) ? "e" : "E");
            case ($urandom_range(2))
                0: doc_q.push_back("+");
                1: doc_q.push_back("-");
                default: ;
            endcase
            n = $urandom_range(3, 1);
            repeat (n) doc_q.push_back(8'($urandom_range("9", "0")));
        end
    endtask

    // Random well-formed value, nesting at most room more levels.
    task automatic add_value(int room);
        int k;
        int n;
        k = $urandom_range(9);
        if (room > 0 && k < 4)
        begin
            n = $urandom_range(3);
            doc_q.push_back(k < 2 ? "{" : "[");
            add_ws();
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                begin
                    doc_q.push_back(",");
                    add_ws();
                end
                if (k < 2)
                begin
                    add_string();
                    add_ws();
                    doc_q.push_back(":");
                    add_ws();
                end
                add_value(room - 1);
                add_ws();
            end
            doc_q.push_back(k < 2 ? "}" : "]");
        end
        else if (k < 6) add_string();
        else if (k < 8) add_number();
        else
            case ($urandom_range(2))
                0: add_text("true");
                1: add_text("false");
                default: add_text("null");
            endcase
    endtask

    // Send one byte and wait for it to be taken; random gaps except in a quiet stretch.
    task automatic send_byte(logic [7:0] b, logic last);
        if ((bytes_sent < 500 || bytes_sent > 800) && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 30) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    // Send the queued bytes; the last one carries the flag when asked.
    task automatic flush_doc(bit mark_last);
        logic [7:0] b;
        while (doc_q.size() > 0)
        begin
            b = doc_q.pop_front();
            send_byte(b, mark_last && doc_q.size() == 0);
        end
    endtask

    // Let the block drain before touching the depth limit.
    task automatic write_limit(logic [7:0] v);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // Broken or finishing tail; the document ends here one way or another.
    task automatic add_tail();
        int n;
        case ($urandom_range(21))
            0: add_text("]");
            1: begin add_text("]"); doc_q.push_back(8'h00); end
            2: begin add_text("]"); doc_q.push_back(8'h00); add_text(" 1"); end
            3: add_text("] x");
            4: begin add_text(",\"a"); doc_q.push_back(8'h01); end
            5: begin add_text(",\""); doc_q.push_back(8'hFF); end
            6: add_text(",\"\\q\"]");
            7: add_text(",\"\\u12g4\"]");
            8: add_text(",\"\\udc00\"]");
            9: add_text(",\"\\ud800x\"]");
            10: add_text(",\"ab");
            11: add_text(",-x]");
            12: add_text(",]");
            13: add_text(",1");
            14: add_text(",{\"a\":1 2}]");
            15: add_text(",{\"a\" 1}]");
            16: add_text(",1 2]");
            17: add_text(",{1}]");
            18:
            begin
                add_text(",");
                repeat (130) doc_q.push_back("[");
            end
            19: add_text(",1.x]");
            20: begin add_text(","); doc_q.push_back(8'h00); end
            default:
            begin
                n = $urandom_range(30, 5);
                repeat (n) doc_q.push_back(8'($urandom_range(255)));
            end
        endcase
    endtask

    initial
    begin
        int n;
        int room;
        logic [7:0] lim;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = 8'h00;
        bytes_sent = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_limit(8'd128);

        // Directed opening: every value kind, all escapes, surrogate pair, UTF-8 leads.
        add_text("[ {\"k\" :[0,-0.5e+3,12E-1,7e9,true,false,null],\"\":{}},[],");
        add_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\u00e9\\uD83D\\uDE00\"");
        add_text(",\"");
        doc_q.push_back(8'hC2); doc_q.push_back(8'h80);
        doc_q.push_back(8'hE0); doc_q.push_back(8'hA0); doc_q.push_back(8'hBF);
        doc_q.push_back(8'hED); doc_q.push_back(8'h9F); doc_q.push_back(8'h80);
        doc_q.push_back(8'hF4); doc_q.push_back(8'h8F); doc_q.push_back(8'hBF);
        doc_q.push_back(8'hBF);
        add_text("\" ");
        flush_doc(1'b0);

        // Full depth of the stack under the largest limit.
        doc_q.push_back(",");
        repeat (127) doc_q.push_back("[");
        repeat (127) doc_q.push_back("]");
        flush_doc(1'b0);

        // Phases of random well-formed values under changing depth limits.
        while (bytes_sent < 1350)
        begin
            case ($urandom_range(4))
                0: lim = 8'd1;
                1: lim = 8'd2;
                2: lim = 8'd128;
                default: lim = 8'($urandom_range(128, 3));
            endcase
            write_limit(lim);
            room = (lim - 1 > 3) ? 3 : lim - 1;
            n = $urandom_range(15, 5);
            repeat (n)
            begin
                doc_q.push_back(",");
                add_ws();
                add_value(room);
                add_ws();
            end
            flush_doc(1'b0);
        end

        add_tail();
        flush_doc(1'b1);
        // Bytes after the end are ignored by the block.
        repeat (8) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
